FILE: hdl/assert_macros.svh
// assertion macros used by sensor_word_crc_check_and_scale
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SWC_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: always");

`define SWC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle implication");

`define SWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle implication");

`else

`define SWC_ASSERT_ALWAYS(label, clk, rst, cond)
`define SWC_ASSERT_IMP(label, clk, rst, ante, cons)
`define SWC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/swcrc_pkg.sv
// types, constants and the crc-8 byte function of the sensor word checker
// no dependencies
`default_nettype none

package swcrc_pkg;

  localparam int MAX_WORDS = 4;
  localparam int WCNT_W    = 3;

  localparam logic [7:0]        CRC_POLY    = 8'h31;
  localparam logic [7:0]        CRC_INIT    = 8'hFF;
  localparam logic [WCNT_W-1:0] WORDS_RESET = 3'd2;

  localparam logic [14:0] TEMP_GAIN   = 15'd17500;
  localparam logic [14:0] HUM_GAIN    = 15'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [16:0] DIV_BASE    = 17'd65535;

  typedef enum logic [1:0] {
    POS_HIGH,
    POS_LOW,
    POS_CHECK
  } pos_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sensor_word_crc_check_and_scale.sv
// Sensor word receiver: takes read-response bytes one item at a time, checks each
// high/low/check-byte triplet with CRC-8 (poly 0x31, init 0xFF) and emits the word
// with a crc flag, a last marker and a scaled value (centidegrees for word 0,
// centipercent for word 1, zero otherwise). A byte with tuser set opens a new read;
// after the last word or a crc failure bytes are dropped until the next start.
// One byte is accepted every clock cycle unless full stages wait on m_axis_tready.
// Three register stages (input, product, result) carry a check byte to its result;
// the input and product stages can still fill while a result waits on m_axis_tready.
// depends on swcrc_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module sensor_word_crc_check_and_scale (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_we,
  input  wire  [swcrc_pkg::WCNT_W-1:0]   cfg_wdata,      // words_per_read
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [7:0]                     s_axis_tdata,   // data_byte
  input  wire  [0:0]                     s_axis_tuser,   // start_req
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [39:0]                    m_axis_tdata,   // word_index, raw_word, scaled_value, pad
  output logic [0:0]                     m_axis_tuser,   // crc_ok
  output logic                           m_axis_tlast    // last
);
  import swcrc_pkg::*;

  logic [WCNT_W-1:0] words_per_read;

  // input stage
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;

  // receiver state
  pos_t       pos, pos_next;
  logic [1:0] cur_word, cur_word_next;
  logic [7:0] crc, crc_next;
  logic [7:0] hi_byte, hi_byte_next;
  logic [7:0] lo_byte, lo_byte_next;
  logic       aborted, aborted_next;

  // product stage
  logic        mid_valid;
  logic [1:0]  mid_index;
  logic [15:0] mid_raw;
  logic        mid_ok;
  logic        mid_last;
  logic        mid_temp;
  logic [30:0] mid_prod;

  // result stage
  logic               out_valid;
  logic [1:0]         out_index;
  logic [15:0]        out_raw;
  logic               out_ok;
  logic               out_last;
  logic signed [14:0] out_scaled;

  logic out_load, mid_load, in_adv;

  // effective view of the state once a start is applied
  pos_t              eff_pos;
  logic [1:0]        eff_word;
  logic [7:0]        eff_crc;
  logic              eff_aborted;
  logic [WCNT_W-1:0] words_eff;
  logic              res_hit;
  logic              res_ok;
  logic              res_last;
  logic [14:0]       res_gain;
  logic [30:0]       res_prod;

  logic [14:0] q_est;
  logic [16:0] rem;
  logic [15:0] quo;
  logic [15:0] scaled16;

  assign out_load      = !out_valid || m_axis_tready;
  assign mid_load      = !mid_valid || out_load;
  assign in_adv        = in_valid && mid_load;
  assign s_axis_tready = !in_valid || mid_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_per_read <= WORDS_RESET;
    end else if (cfg_we) begin
      words_per_read <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser[0];
    end
  end

  // outputs of the receiver for the item in the input stage
  always_comb begin
    eff_pos     = in_start ? POS_HIGH : pos;
    eff_word    = in_start ? 2'd0 : cur_word;
    eff_crc     = in_start ? CRC_INIT : crc;
    eff_aborted = in_start ? 1'b0 : aborted;

    if (words_per_read == '0) begin
      words_eff = WCNT_W'(1);
    end else if (words_per_read > WCNT_W'(MAX_WORDS)) begin
      words_eff = WCNT_W'(MAX_WORDS);
    end else begin
      words_eff = words_per_read;
    end

    res_hit  = in_valid && !eff_aborted && (eff_pos == POS_CHECK);
    res_ok   = (in_byte == eff_crc);
    res_last = !res_ok || ((WCNT_W'(eff_word) + WCNT_W'(1)) >= words_eff);

    case (eff_word)
      2'd0:    res_gain = TEMP_GAIN;
      2'd1:    res_gain = HUM_GAIN;
      default: res_gain = '0;
    endcase
    res_prod = 31'(res_gain) * 31'({hi_byte, lo_byte});
  end

  // next state of the receiver
  always_comb begin
    pos_next      = pos;
    cur_word_next = cur_word;
    crc_next      = crc;
    hi_byte_next  = hi_byte;
    lo_byte_next  = lo_byte;
    aborted_next  = aborted;

    if (in_adv) begin
      pos_next      = eff_pos;
      cur_word_next = eff_word;
      crc_next      = eff_crc;
      aborted_next  = eff_aborted;
      if (!eff_aborted) begin
        unique case (eff_pos)
          POS_HIGH: begin
            hi_byte_next = in_byte;
            crc_next     = crc8_byte(eff_crc, in_byte);
            pos_next     = POS_LOW;
          end
          POS_LOW: begin
            lo_byte_next = in_byte;
            crc_next     = crc8_byte(eff_crc, in_byte);
            pos_next     = POS_CHECK;
          end
          POS_CHECK: begin
            pos_next = POS_HIGH;
            crc_next = CRC_INIT;
            if (res_last) begin
              aborted_next = 1'b1;
            end else begin
              cur_word_next = eff_word + 2'd1;
            end
          end
          default: begin
            pos_next = POS_HIGH;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= POS_HIGH;
      cur_word <= '0;
      crc      <= CRC_INIT;
      hi_byte  <= '0;
      lo_byte  <= '0;
      aborted  <= 1'b1;
    end else begin
      pos      <= pos_next;
      cur_word <= cur_word_next;
      crc      <= crc_next;
      hi_byte  <= hi_byte_next;
      lo_byte  <= lo_byte_next;
      aborted  <= aborted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_load) begin
      mid_valid <= in_adv && res_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_load) begin
      mid_index <= eff_word;
      mid_raw   <= {hi_byte, lo_byte};
      mid_ok    <= res_ok;
      mid_last  <= res_last;
      mid_temp  <= (eff_word == 2'd0);
      mid_prod  <= res_prod;
    end
  end

  // floor(prod / 65535): estimate by shift, one correction step
  always_comb begin
    q_est    = mid_prod[30:16];
    rem      = {1'b0, mid_prod[15:0]} + {2'b0, q_est};
    quo      = {1'b0, q_est} + 16'(rem >= DIV_BASE);
    scaled16 = quo - (mid_temp ? TEMP_OFFSET : 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index  <= mid_index;
      out_raw    <= mid_raw;
      out_ok     <= mid_ok;
      out_last   <= mid_last;
      out_scaled <= scaled16[14:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_scaled, out_raw, out_index};
  assign m_axis_tuser  = out_ok;
  assign m_axis_tlast  = out_last;

  `SWC_ASSERT_ALWAYS(a_pos_legal, clk, rst, pos != 2'd3)
  `SWC_ASSERT_IMP(a_fail_is_last, clk, rst, mid_valid && !mid_ok, mid_last)
  `SWC_ASSERT_IMP(a_other_words_zero, clk, rst,
                  out_valid && out_index[1], out_scaled == 15'sd0)
  `SWC_ASSERT_NEXT(a_start_opens, clk, rst, in_adv && in_start,
                   pos == POS_LOW && !aborted && cur_word == 2'd0)
  `SWC_ASSERT_NEXT(a_idle_holds, clk, rst, in_adv && aborted && !in_start,
                   aborted && $stable(pos) && $stable(crc) && !mid_valid)

endmodule

`default_nettype wire
